@@ hw/rtl/rled_pkg.sv @@
// ----------------------------------------------------------------------------
// rled_pkg
// Shared types, constants and the brightness factor table for the RGB LED
// strip duty encoder.
// ----------------------------------------------------------------------------
package rled_pkg;

  // pixel store geometry
  localparam int LED_COUNT_MAX  = 128;
  localparam int ADDR_W         = (LED_COUNT_MAX > 1) ? $clog2(LED_COUNT_MAX) : 1;
  localparam int IDX_W          = 7;

  // field widths
  localparam int CH_W           = 8;
  localparam int PIX_W          = 3 * CH_W;
  localparam int FACTOR_W       = 17;
  localparam int ACC_W          = CH_W + FACTOR_W - 1;
  localparam int CNT_W          = 7;

  // run lengths and limits
  localparam int BITS_PER_PIXEL = 24;
  localparam int BRIGHT_MAX     = 45;
  localparam int GAP_MAX        = 64;

  // operation codes carried in tuser
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EMIT  = 2'd1;
  localparam logic [1:0] OP_GAP   = 2'd2;

  // configuration register indices
  localparam logic [1:0] REG_BRIGHTNESS  = 2'd0;
  localparam logic [1:0] REG_HIGH_DUTY   = 2'd1;
  localparam logic [1:0] REG_LOW_DUTY    = 2'd2;
  localparam logic [1:0] REG_RESET_SLOTS = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MULT,
    ST_SEND_PIX,
    ST_SEND_GAP
  } state_t;

  // tan(step degrees) in unsigned 1.16, step already clamped to 0..45
  function automatic logic [FACTOR_W-1:0] bright_factor(input logic [5:0] step);
    logic [FACTOR_W-1:0] f;
    case (step)
      6'd0:  f = 17'd0;
      6'd1:  f = 17'd1144;
      6'd2:  f = 17'd2289;
      6'd3:  f = 17'd3435;
      6'd4:  f = 17'd4583;
      6'd5:  f = 17'd5734;
      6'd6:  f = 17'd6888;
      6'd7:  f = 17'd8047;
      6'd8:  f = 17'd9210;
      6'd9:  f = 17'd10380;
      6'd10: f = 17'd11556;
      6'd11: f = 17'd12739;
      6'd12: f = 17'd13930;
      6'd13: f = 17'd15130;
      6'd14: f = 17'd16340;
      6'd15: f = 17'd17560;
      6'd16: f = 17'd18792;
      6'd17: f = 17'd20036;
      6'd18: f = 17'd21294;
      6'd19: f = 17'd22566;
      6'd20: f = 17'd23853;
      6'd21: f = 17'd25157;
      6'd22: f = 17'd26478;
      6'd23: f = 17'd27818;
      6'd24: f = 17'd29179;
      6'd25: f = 17'd30560;
      6'd26: f = 17'd31964;
      6'd27: f = 17'd33392;
      6'd28: f = 17'd34846;
      6'd29: f = 17'd36327;
      6'd30: f = 17'd37837;
      6'd31: f = 17'd39378;
      6'd32: f = 17'd40951;
      6'd33: f = 17'd42560;
      6'd34: f = 17'd44205;
      6'd35: f = 17'd45889;
      6'd36: f = 17'd47615;
      6'd37: f = 17'd49385;
      6'd38: f = 17'd51202;
      6'd39: f = 17'd53070;
      6'd40: f = 17'd54991;
      6'd41: f = 17'd56970;
      6'd42: f = 17'd59009;
      6'd43: f = 17'd61113;
      6'd44: f = 17'd63287;
      default: f = 17'd65536;
    endcase
    return f;
  endfunction

endpackage

@@ hw/rtl/rgb_led_strip_duty_encoder.sv @@
// ----------------------------------------------------------------------------
// rgb_led_strip_duty_encoder
// Pixel store with brightness scaling and serial PWM duty code output.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  tdata: led_index, red, green, blue
//                                         tuser: operation
//  m_*      out        m_tvalid/m_tready  tdata: duty, tlast: last
//  cfg_*    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
//  A write item is taken in its accept cycle. An emit item passes through the
//  accept cycle (store read), operand load, bit-serial scaling (one channel
//  bit per cycle, three channels side by side) and 24 slots; no new item is
//  taken until the last slot of the pixel is loaded.
//  A gap item passes through the accept cycle and then min(reset_slots, 64)
//  slots, one per cycle while the output is not stalled; an empty gap ends there.
//  Reset clears the store valid bits at once and restores register defaults.
//  A stalled output holds the slot register; the sequencer returns to idle
//  and takes the next input item once the last slot of a run is loaded into it.
//
module rgb_led_strip_duty_encoder
  import rled_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // led_index[6:0], red[14:7], green[22:15], blue[30:23]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // duty[7:0]
  output logic        m_tlast,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // input field split
  logic [1:0]       op;
  logic [IDX_W-1:0] led_index;
  logic [CH_W-1:0]  red, green, blue;
  assign op        = s_tuser;
  assign led_index = s_tdata[6:0];
  assign red       = s_tdata[14:7];
  assign green     = s_tdata[22:15];
  assign blue      = s_tdata[30:23];

  logic [ADDR_W-1:0] addr;
  logic              in_range;
  assign addr     = ADDR_W'(led_index);
  assign in_range = 13'(led_index) < 13'(LED_COUNT_MAX);

  // configuration registers
  logic [5:0] brightness;
  logic [7:0] high_duty;
  logic [7:0] low_duty;
  logic [6:0] reset_slots;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness  <= 6'd45;
      high_duty   <= 8'd150;
      low_duty    <= 8'd75;
      reset_slots <= 7'd50;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BRIGHTNESS:  brightness  <= cfg_data[5:0];
        REG_HIGH_DUTY:   high_duty   <= cfg_data;
        REG_LOW_DUTY:    low_duty    <= cfg_data;
        REG_RESET_SLOTS: reset_slots <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // clamped brightness step and gap length
  logic [5:0]       step;
  logic [CNT_W-1:0] gap_n;
  assign step  = (brightness > 6'(BRIGHT_MAX)) ? 6'(BRIGHT_MAX) : brightness;
  assign gap_n = (reset_slots > 7'(GAP_MAX)) ? 7'(GAP_MAX) : reset_slots;

  // sequencer
  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             in_acc;
  logic             slot_load;
  logic             slot_last;
  logic             mult_done;

  logic m_tvalid_r;
  assign m_tvalid = m_tvalid_r;

  assign in_acc = s_tvalid && s_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_EMIT: state_next = ST_READ;
            OP_GAP:  state_next = (gap_n != '0) ? ST_SEND_GAP : ST_IDLE;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ:     state_next = ST_MULT;
      ST_MULT:     state_next = mult_done ? ST_SEND_PIX : ST_MULT;
      ST_SEND_PIX: state_next = (slot_load && slot_last) ? ST_IDLE : ST_SEND_PIX;
      ST_SEND_GAP: state_next = (slot_load && slot_last) ? ST_IDLE : ST_SEND_GAP;
      default:     state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    slot_load = 1'b0;
    slot_last = 1'b0;
    mult_done = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_MULT: mult_done = (cnt[2:0] == 3'd7);
      ST_SEND_PIX: begin
        slot_load = !m_tvalid_r || m_tready;
        slot_last = (cnt == CNT_W'(BITS_PER_PIXEL - 1));
      end
      ST_SEND_GAP: begin
        slot_load = !m_tvalid_r || m_tready;
        slot_last = (cnt == gap_n - 7'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        cnt <= '0;
      end else if (state == ST_MULT || slot_load) begin
        cnt <= cnt + 7'd1;
      end
    end
  end

  // pixel store with valid bits
  logic [PIX_W-1:0] mem [LED_COUNT_MAX];
  logic [LED_COUNT_MAX-1:0] pix_valid;
  logic [PIX_W-1:0] rd_data;
  logic             rd_ok;

  always_ff @(posedge clk) begin
    if (in_acc && op == OP_WRITE && in_range) begin
      mem[addr] <= {green, red, blue};
    end
    if (in_acc) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= '0;
      rd_ok     <= 1'b0;
    end else if (in_acc) begin
      if (op == OP_WRITE && in_range) begin
        pix_valid[addr] <= 1'b1;
      end
      rd_ok <= in_range && pix_valid[addr];
    end
  end

  // bit-serial scaling, one multiplier bit per channel per cycle
  logic [CH_W-1:0]  c_g, c_r, c_b;
  logic [ACC_W-1:0] fsh;
  logic [ACC_W-1:0] acc_g, acc_r, acc_b;
  logic [ACC_W-1:0] acc_g_next, acc_r_next, acc_b_next;
  logic [PIX_W-1:0] pix;

  assign pix        = rd_ok ? rd_data : '0;
  assign acc_g_next = acc_g + (c_g[0] ? fsh : '0);
  assign acc_r_next = acc_r + (c_r[0] ? fsh : '0);
  assign acc_b_next = acc_b + (c_b[0] ? fsh : '0);

  // operand, accumulator and slot word registers
  logic [PIX_W-1:0] word;

  always_ff @(posedge clk) begin
    case (state)
      ST_READ: begin
        c_g   <= pix[23:16];
        c_r   <= pix[15:8];
        c_b   <= pix[7:0];
        fsh   <= ACC_W'(bright_factor(step));
        acc_g <= '0;
        acc_r <= '0;
        acc_b <= '0;
      end
      ST_MULT: begin
        c_g   <= c_g >> 1;
        c_r   <= c_r >> 1;
        c_b   <= c_b >> 1;
        fsh   <= fsh << 1;
        acc_g <= acc_g_next;
        acc_r <= acc_r_next;
        acc_b <= acc_b_next;
        if (mult_done) begin
          word <= {acc_g_next[ACC_W-1 -: CH_W], acc_r_next[ACC_W-1 -: CH_W],
                   acc_b_next[ACC_W-1 -: CH_W]};
        end
      end
      ST_SEND_PIX: begin
        if (slot_load) begin
          word <= word << 1;
        end
      end
      default: ;
    endcase
  end

  // output slot register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid_r <= 1'b0;
    end else if (slot_load) begin
      m_tvalid_r <= 1'b1;
    end else if (m_tready) begin
      m_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_load) begin
      m_tlast <= slot_last;
      if (state == ST_SEND_PIX) begin
        m_tdata <= word[PIX_W-1] ? high_duty : low_duty;
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule
